@@ src/segi_pkg.sv @@
// Shared constants and types for the segment intersection core.
package segi_pkg;

	localparam int DEF_COORD_BITS    = 24;
	localparam int DEF_FRACTION_BITS = 16;
	localparam int OUTCOME_BITS      = 2;

	typedef enum logic [OUTCOME_BITS-1:0] {
		OUTC_HIT      = 2'd0,
		OUTC_PARALLEL = 2'd1,
		OUTC_MISS     = 2'd2
	} outcome_t;

	// Control that travels alongside a word through the divider.
	typedef struct packed {
		logic     full;
		outcome_t outcome;
	} div_ctl_t;

endpackage

@@ src/segi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module segi_div #(
	parameter int NUM_W  = 50,
	parameter int FRAC_W = 16,
	parameter int SIDE_W = 98
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  segi_pkg::div_ctl_t       in_ctl,
	input  logic [NUM_W-1:0]         in_rem,
	input  logic [NUM_W-1:0]         in_den,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	input  logic                     out_ready,
	output segi_pkg::div_ctl_t       out_ctl,
	output logic [FRAC_W-1:0]        out_quo,
	output logic [SIDE_W-1:0]        out_side
);
	import segi_pkg::*;

	// Index 0 is the input, index k the register of divider stage k.
	logic              vld_sk  [FRAC_W:0];
	logic [NUM_W-1:0]  rem_sk  [FRAC_W:0];
	logic [NUM_W-1:0]  den_sk  [FRAC_W:0];
	logic [FRAC_W-1:0] quo_sk  [FRAC_W:0];
	div_ctl_t          ctl_sk  [FRAC_W:0];
	logic [SIDE_W-1:0] side_sk [FRAC_W:0];
	logic              rdy     [FRAC_W+1:1];

	assign vld_sk[0]  = in_valid;
	assign rem_sk[0]  = in_rem;
	assign den_sk[0]  = in_den;
	assign quo_sk[0]  = '0;
	assign ctl_sk[0]  = in_ctl;
	assign side_sk[0] = in_side;

	// A stage may load when it is empty or its word moves on.
	always_comb begin
		rdy[FRAC_W+1] = out_ready;
		for (int k = FRAC_W; k >= 1; k--) begin
			rdy[k] = !vld_sk[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[1];

	for (genvar k = 1; k <= FRAC_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_dbl;
		logic             take;

		assign rem_dbl = {rem_sk[k-1][NUM_W-2:0], 1'b0};
		assign take    = rem_dbl >= den_sk[k-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_sk[k] <= vld_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_sk[k]  <= take ? rem_dbl - den_sk[k-1] : rem_dbl;
				den_sk[k]  <= den_sk[k-1];
				quo_sk[k]  <= {quo_sk[k-1][FRAC_W-2:0], take};
				ctl_sk[k]  <= ctl_sk[k-1];
				side_sk[k] <= side_sk[k-1];
			end
		end
	end

	assign out_valid = vld_sk[FRAC_W];
	assign out_ctl   = ctl_sk[FRAC_W];
	assign out_quo   = quo_sk[FRAC_W];
	assign out_side  = side_sk[FRAC_W];

endmodule

@@ src/segment_intersection_core.sv @@
// Top level of the segment intersection core.
//
// The core takes one word holding two line segments, A from a_start to a_end and B from
// b_start to b_end, and returns one word per input: hit, outcome (hit, parallel or
// collinear, no crossing), the fraction along A as unsigned Q1.FRACTION_BITS with the
// end of A as exactly 1.0, and the crossing point, which is zero when there is no hit.
// The pipeline accepts a new word every clock cycle while in_stall is low. On its way
// to the result a word passes, in order: five stages form the differences,
// the cross products, the denominator and numerators, the sign normalization and the
// range tests; FRACTION_BITS stages of the restoring divider produce one fraction bit
// each; one stage multiplies the fraction by the direction of A, and the output
// register adds the start point. Every stage carries its own valid bit and loads
// whenever it is empty or its word moves on, so bubbles close up behind a stalled
// output and the core keeps accepting until the pipeline is truly full.
module segment_intersection_core #(
	parameter int COORD_BITS    = segi_pkg::DEF_COORD_BITS,
	parameter int FRACTION_BITS = segi_pkg::DEF_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  a_start_x,
	input  logic signed [COORD_BITS-1:0]  a_start_y,
	input  logic signed [COORD_BITS-1:0]  a_end_x,
	input  logic signed [COORD_BITS-1:0]  a_end_y,
	input  logic signed [COORD_BITS-1:0]  b_start_x,
	input  logic signed [COORD_BITS-1:0]  b_start_y,
	input  logic signed [COORD_BITS-1:0]  b_end_x,
	input  logic signed [COORD_BITS-1:0]  b_end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [segi_pkg::OUTCOME_BITS-1:0] outcome,
	output logic signed [COORD_BITS-1:0]  cross_x,
	output logic signed [COORD_BITS-1:0]  cross_y,
	output logic [FRACTION_BITS:0]        fraction
);
	import segi_pkg::*;

	// Differences need one extra bit, products twice that, sums of products one more.
	localparam int DIF_W  = COORD_BITS + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int SUM_W  = PRD_W + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int FRC_W  = FRACTION_BITS + 1;
	localparam int MUL_W  = FRC_W + 1 + DIF_W;
	localparam int SIDE_W = 2 * DIF_W + 2 * COORD_BITS;

	// Stage 1: direction vectors and the offset between the start points.
	logic                    vld_s1;
	logic signed [DIF_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, wx_s1, wy_s1;
	logic signed [COORD_BITS-1:0] p0x_s1, p0y_s1;

	// Stage 2: the six cross products.
	logic                    vld_s2;
	logic signed [PRD_W-1:0] ab_s2, ba_s2, awy_s2, ayw_s2, bwy_s2, byw_s2;
	logic signed [DIF_W-1:0] ax_s2, ay_s2;
	logic signed [COORD_BITS-1:0] p0x_s2, p0y_s2;

	// Stage 3: denominator and the two numerators.
	logic                    vld_s3;
	logic signed [SUM_W-1:0] den_s3, sn_s3, tn_s3;
	logic signed [DIF_W-1:0] ax_s3, ay_s3;
	logic signed [COORD_BITS-1:0] p0x_s3, p0y_s3;

	// Stage 4: signs made relative to a positive denominator.
	logic                    vld_s4, dzero_s4;
	logic signed [SUM_W-1:0] den_s4, sn_s4, tn_s4;
	logic signed [DIF_W-1:0] ax_s4, ay_s4;
	logic signed [COORD_BITS-1:0] p0x_s4, p0y_s4;

	// Stage 5: classification and divider operands.
	logic                    vld_s5;
	div_ctl_t                ctl_s5;
	logic [MAG_W-1:0]        rem_s5, den_s5;
	logic [SIDE_W-1:0]       side_s5;

	// Divider output.
	logic                    div_in_ready, div_vld;
	div_ctl_t                div_ctl;
	logic [FRACTION_BITS-1:0] div_quo;
	logic [SIDE_W-1:0]       div_side;
	logic signed [DIF_W-1:0] div_ax, div_ay;
	logic signed [COORD_BITS-1:0] div_p0x, div_p0y;
	logic [FRC_W-1:0]        frac_sel;

	// Stage 6: fraction times the direction of A.
	logic                    vld_s6;
	outcome_t                outc_s6;
	logic [FRC_W-1:0]        frac_s6;
	logic signed [MUL_W-1:0] mulx_s6, muly_s6;
	logic signed [COORD_BITS-1:0] p0x_s6, p0y_s6;

	// Output register.
	logic                    out_valid_q;
	outcome_t                outc_q;
	logic [FRC_W-1:0]        frac_q;
	logic signed [COORD_BITS-1:0] cross_x_q, cross_y_q;

	logic rdy_out, rdy6, rdy5, rdy4, rdy3, rdy2, rdy1;
	logic signed [MUL_W-1:0] offx, offy;
	logic                    hit_s6;

	// Each register loads when it is empty or when the register after it loads; the output register when out_stall is low.
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy6     = !vld_s6 || rdy_out;
	assign rdy5     = !vld_s5 || div_in_ready;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy6) begin
				vld_s6 <= div_vld;
			end
			if (rdy_out) begin
				out_valid_q <= vld_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ax_s1  <= DIF_W'(a_end_x) - DIF_W'(a_start_x);
			ay_s1  <= DIF_W'(a_end_y) - DIF_W'(a_start_y);
			bx_s1  <= DIF_W'(b_end_x) - DIF_W'(b_start_x);
			by_s1  <= DIF_W'(b_end_y) - DIF_W'(b_start_y);
			wx_s1  <= DIF_W'(a_start_x) - DIF_W'(b_start_x);
			wy_s1  <= DIF_W'(a_start_y) - DIF_W'(b_start_y);
			p0x_s1 <= a_start_x;
			p0y_s1 <= a_start_y;
		end
		if (rdy2) begin
			ab_s2  <= PRD_W'(ax_s1) * PRD_W'(by_s1);
			ba_s2  <= PRD_W'(bx_s1) * PRD_W'(ay_s1);
			awy_s2 <= PRD_W'(ax_s1) * PRD_W'(wy_s1);
			ayw_s2 <= PRD_W'(ay_s1) * PRD_W'(wx_s1);
			bwy_s2 <= PRD_W'(bx_s1) * PRD_W'(wy_s1);
			byw_s2 <= PRD_W'(by_s1) * PRD_W'(wx_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			p0x_s2 <= p0x_s1;
			p0y_s2 <= p0y_s1;
		end
		if (rdy3) begin
			den_s3 <= SUM_W'(ab_s2) - SUM_W'(ba_s2);
			sn_s3  <= SUM_W'(awy_s2) - SUM_W'(ayw_s2);
			tn_s3  <= SUM_W'(bwy_s2) - SUM_W'(byw_s2);
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			p0x_s3 <= p0x_s2;
			p0y_s3 <= p0y_s2;
		end
		if (rdy4) begin
			// A negative denominator flips all three signs.
			den_s4   <= den_s3[SUM_W-1] ? -den_s3 : den_s3;
			sn_s4    <= den_s3[SUM_W-1] ? -sn_s3 : sn_s3;
			tn_s4    <= den_s3[SUM_W-1] ? -tn_s3 : tn_s3;
			dzero_s4 <= (den_s3 == '0);
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			p0x_s4   <= p0x_s3;
			p0y_s4   <= p0y_s3;
		end
		if (rdy5) begin
			if (dzero_s4) begin
				ctl_s5.outcome <= OUTC_PARALLEL;
			end else if (sn_s4[SUM_W-1] || tn_s4[SUM_W-1] ||
				sn_s4 > den_s4 || tn_s4 > den_s4) begin
				ctl_s5.outcome <= OUTC_MISS;
			end else begin
				ctl_s5.outcome <= OUTC_HIT;
			end
			// Both ends are included, so a numerator equal to the denominator is 1.0.
			ctl_s5.full <= (tn_s4 == den_s4);
			rem_s5      <= MAG_W'(tn_s4);
			den_s5      <= MAG_W'(den_s4);
			side_s5     <= {ax_s4, ay_s4, p0x_s4, p0y_s4};
		end
	end

	segi_div #(
		.NUM_W  (MAG_W),
		.FRAC_W (FRACTION_BITS),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_ready  (div_in_ready),
		.in_ctl    (ctl_s5),
		.in_rem    (rem_s5),
		.in_den    (den_s5),
		.in_side   (side_s5),
		.out_valid (div_vld),
		.out_ready (rdy6),
		.out_ctl   (div_ctl),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	assign {div_ax, div_ay, div_p0x, div_p0y} = div_side;
	assign frac_sel = div_ctl.full ? {1'b1, {FRACTION_BITS{1'b0}}} : {1'b0, div_quo};

	always_ff @(posedge clk) begin
		if (rdy6) begin
			outc_s6 <= div_ctl.outcome;
			frac_s6 <= frac_sel;
			mulx_s6 <= MUL_W'($signed({1'b0, frac_sel})) * MUL_W'(div_ax);
			muly_s6 <= MUL_W'($signed({1'b0, frac_sel})) * MUL_W'(div_ay);
			p0x_s6  <= div_p0x;
			p0y_s6  <= div_p0y;
		end
	end

	// The arithmetic shift rounds the offset toward minus infinity.
	assign offx   = mulx_s6 >>> FRACTION_BITS;
	assign offy   = muly_s6 >>> FRACTION_BITS;
	assign hit_s6 = (outc_s6 == OUTC_HIT);

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			outc_q    <= outc_s6;
			frac_q    <= hit_s6 ? frac_s6 : '0;
			cross_x_q <= hit_s6 ? p0x_s6 + COORD_BITS'(offx) : '0;
			cross_y_q <= hit_s6 ? p0y_s6 + COORD_BITS'(offy) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = (outc_q == OUTC_HIT);
	assign outcome   = outc_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;
	assign fraction  = frac_q;

endmodule
